@@ rtl/core/sipq_pkg.sv @@
// ---------------------------------------------------------------------------
// sipq_pkg
// Types, constants and codes of the sorted-insertion priority queue.
// ---------------------------------------------------------------------------
package sipq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 32;

  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the item and result fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new item and clear the scan state
    logic rd;      // read the next stored entry
    logic finish;  // last write, count update and result register load
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the operation walks through the stored entries
    logic scan_end;   // every stored entry has been read
    logic pend;       // a read is still in flight
  } dp_stat_t;

endpackage

@@ rtl/core/sipq_datapath.sv @@
// ---------------------------------------------------------------------------
// sipq_datapath
// Entry memory, scan pipeline, count and mode registers, result registers.
// ---------------------------------------------------------------------------
module sipq_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sipq_pkg::dp_cmd_t         cmd_i,
  output sipq_pkg::dp_stat_t        stat_o,
  input  logic [sipq_pkg::OP_W-1:0] operation_i,
  input  logic [sipq_pkg::ITEM_W-1:0] item_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  output logic [sipq_pkg::ITEM_W-1:0] item_out_o,
  output logic                      found_o,
  output logic [sipq_pkg::STATUS_W-1:0] status_o,
  output logic [sipq_pkg::COUNT_W-1:0]  count_o
);

  logic [sipq_pkg::KEY_W-1:0] mem [sipq_pkg::CAPACITY];

  logic                        mode_q;
  logic [sipq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [sipq_pkg::CNT_W-1:0]  idx_q;
  logic                        pend_q;
  logic                        placed_q;
  logic                        found_q;

  sipq_pkg::op_e               op_q;
  logic [sipq_pkg::KEY_W-1:0]  key_q;
  logic [sipq_pkg::KEY_W-1:0]  carry_q;
  logic [sipq_pkg::KEY_W-1:0]  head_q;
  logic [sipq_pkg::KEY_W-1:0]  rd_data_q;
  logic [sipq_pkg::IDX_W-1:0]  p_idx_q;

  logic                        full;
  logic                        wr_en;
  logic [sipq_pkg::IDX_W-1:0]  wr_addr;
  logic [sipq_pkg::KEY_W-1:0]  wr_data;

  logic [sipq_pkg::ITEM_W-1:0]   res_item;
  logic                          res_found;
  sipq_pkg::status_e             res_status;

  logic [sipq_pkg::ITEM_W-1:0]   item_out_q;
  logic                          found_out_q;
  logic [sipq_pkg::STATUS_W-1:0] status_out_q;
  logic [sipq_pkg::COUNT_W-1:0]  count_out_q;

  assign full = (count_q == sipq_pkg::CNT_W'(sipq_pkg::CAPACITY));

  always_comb begin
    stat_o.scan_end = (idx_q == count_q);
    stat_o.pend     = pend_q;
    unique case (op_q)
      sipq_pkg::OP_INSERT:   stat_o.need_scan = mode_q && !full;
      sipq_pkg::OP_REMOVE:   stat_o.need_scan = (count_q != '0);
      sipq_pkg::OP_CONTAINS: stat_o.need_scan = 1'b1;
      default:               stat_o.need_scan = 1'b0;
    endcase
  end

  // One write per cycle: either the ripple of a scanned entry or the
  // closing write at the tail.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[sipq_pkg::IDX_W-1:0];
    wr_data = key_q;
    if (pend_q) begin
      unique case (op_q)
        sipq_pkg::OP_INSERT: begin
          if (!placed_q && (rd_data_q >= key_q)) begin
            wr_en   = 1'b1;
            wr_addr = p_idx_q;
            wr_data = key_q;
          end else if (placed_q) begin
            wr_en   = 1'b1;
            wr_addr = p_idx_q;
            wr_data = carry_q;
          end
        end
        sipq_pkg::OP_REMOVE: begin
          if (p_idx_q != '0) begin
            wr_en   = 1'b1;
            wr_addr = p_idx_q - sipq_pkg::IDX_W'(1);
            wr_data = rd_data_q;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end else if (cmd_i.finish && (op_q == sipq_pkg::OP_INSERT) && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[sipq_pkg::IDX_W-1:0];
      wr_data = placed_q ? carry_q : key_q;
    end
  end

  // Result of the operation, valid while finish is asserted.
  always_comb begin
    count_d    = count_q;
    res_item   = '0;
    res_found  = 1'b0;
    res_status = sipq_pkg::STAT_OK;
    unique case (op_q)
      sipq_pkg::OP_INSERT: begin
        if (full) begin
          res_status = sipq_pkg::STAT_FULL;
        end else begin
          count_d = count_q + sipq_pkg::CNT_W'(1);
        end
      end
      sipq_pkg::OP_REMOVE: begin
        if (count_q == '0) begin
          res_status = sipq_pkg::STAT_EMPTY;
        end else begin
          count_d  = count_q - sipq_pkg::CNT_W'(1);
          res_item = sipq_pkg::ITEM_W'(head_q);
        end
      end
      sipq_pkg::OP_CONTAINS: begin
        res_found = found_q;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      count_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      placed_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      pend_q <= cmd_i.rd;
      if (cmd_i.load) begin
        idx_q    <= '0;
        placed_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          idx_q <= idx_q + sipq_pkg::CNT_W'(1);
        end
        if (pend_q && (op_q == sipq_pkg::OP_INSERT) && (rd_data_q >= key_q)) begin
          placed_q <= 1'b1;
        end
        if (pend_q && (op_q == sipq_pkg::OP_CONTAINS) && (rd_data_q == key_q)) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= sipq_pkg::op_e'(operation_i);
      key_q <= sipq_pkg::KEY_W'(item_i);
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[idx_q[sipq_pkg::IDX_W-1:0]];
      p_idx_q   <= idx_q[sipq_pkg::IDX_W-1:0];
    end
    if (pend_q) begin
      // Once the slot is found, each displaced entry moves one place on.
      if (placed_q || (rd_data_q >= key_q)) begin
        carry_q <= rd_data_q;
      end
      if (p_idx_q == '0) begin
        head_q <= rd_data_q;
      end
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.finish) begin
      item_out_q   <= res_item;
      found_out_q  <= res_found;
      status_out_q <= res_status;
      count_out_q  <= sipq_pkg::COUNT_W'(count_d);
    end
  end

  assign item_out_o = item_out_q;
  assign found_o    = found_out_q;
  assign status_o   = status_out_q;
  assign count_o    = count_out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sipq_pkg::CNT_W'(sipq_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_rd_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (idx_q < count_q))
    else $error("read issued past the stored entries");

  a_finish_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !pend_q)
    else $error("finish while a scanned entry is still pending");

  a_count_stable_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd || pend_q) |=> $stable(count_q))
    else $error("count changed during a scan");

endmodule

@@ rtl/core/sipq_ctrl.sv @@
// ---------------------------------------------------------------------------
// sipq_ctrl
// Sequencer of the queue: takes an item, walks the scan, hands off the result.
// ---------------------------------------------------------------------------
module sipq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sipq_pkg::dp_cmd_t  cmd_o,
  input  sipq_pkg::dp_stat_t stat_i
);

  sipq_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sipq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != sipq_pkg::S_IDLE);
    unique case (state_q)
      sipq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sipq_pkg::S_SCAN;
        end
      end
      sipq_pkg::S_SCAN: begin
        if (!stat_i.need_scan || (stat_i.scan_end && !stat_i.pend)) begin
          state_d = sipq_pkg::S_LAST;
        end else begin
          cmd_o.rd = !stat_i.scan_end;
        end
      end
      sipq_pkg::S_LAST: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = sipq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sipq_pkg::S_IDLE;
      end
    endcase
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign out_valid_o = out_valid_q;

  a_finish_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.finish)
    else $error("result register overwritten while stalled");

  a_load_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == sipq_pkg::S_SCAN))
    else $error("load did not start a scan");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.rd, cmd_o.finish}))
    else $error("more than one datapath command at once");

endmodule

@@ rtl/core/sorted_insertion_priority_queue_top.sv @@
// ---------------------------------------------------------------------------
// sorted_insertion_priority_queue_top
// Fixed-capacity key queue with insert, remove-first and contains.
// ---------------------------------------------------------------------------
// Input channel: in_valid_i/in_stall_o carry one item (operation_i, item_i).
// Output channel: out_valid_o/out_stall_i carry one result per item
// (item_out_o, found_o, status_o, count_o). A transfer happens on a rising
// edge with valid high and stall low.
// The sorted_mode register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the queue is idle, and the block does not enforce
// this. It resets to 1 (ascending order). Insert in sorted mode, remove and
// contains walk the n stored entries through the entry memory, one entry per
// cycle with a registered read and a write-back in the cycle after it. FIFO
// inserts, dropped inserts, removes on empty and unused codes do not walk the
// entries; a contains on an empty queue walks none.
// The input is stalled while an item is in work. The finished result waits
// in the output register; if the receiver is still stalling the previous
// result, the queue holds the new one back and keeps the input stalled.
// Reset empties the queue and clears the output valid.
// ---------------------------------------------------------------------------
module sorted_insertion_priority_queue_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sipq_pkg::OP_W-1:0]       operation_i,
  input  logic [sipq_pkg::ITEM_W-1:0]     item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sipq_pkg::ITEM_W-1:0]     item_out_o,
  output logic                            found_o,
  output logic [sipq_pkg::STATUS_W-1:0]   status_o,
  output logic [sipq_pkg::COUNT_W-1:0]    count_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i
);

  sipq_pkg::dp_cmd_t  cmd;
  sipq_pkg::dp_stat_t stat;

  sipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  sipq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation_i),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_out_o  (item_out_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule
